// ===== design/ffha_pkg.sv =====
package ffha_pkg;

    localparam int REQ_W     = 16;
    localparam int OFF_W     = 12;
    localparam int STATUS_W  = 3;
    localparam int FREE_W    = 13;
    localparam int DIV_W     = 16;
    localparam int DIV_CNT_W = 4;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_OK       = 3'd0;
    localparam status_t STATUS_SIZE     = 3'd1;
    localparam status_t STATUS_OOM      = 3'd2;
    localparam status_t STATUS_NOTFOUND = 3'd3;
    localparam status_t STATUS_OUTSIDE  = 3'd4;

    localparam logic ACTION_ALLOC = 1'b0;
    localparam logic ACTION_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_READ,
        S_BLOCK,
        S_MERGE,
        S_FIT,
        S_SPLIT,
        S_DONE
    } state_t;

endpackage

// ===== design/ffha_req_if.sv =====
interface ffha_req_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [ffha_pkg::REQ_W-1:0]  request_bytes;
    logic [ffha_pkg::OFF_W-1:0]  release_offset;

    modport source (output valid, output action, output request_bytes,
                    output release_offset, input ready);
    modport sink   (input valid, input action, input request_bytes,
                    input release_offset, output ready);
endinterface

// ===== design/ffha_rsp_if.sv =====
interface ffha_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ffha_pkg::STATUS_W-1:0] status;
    logic [ffha_pkg::OFF_W-1:0]   data_offset;
    logic [ffha_pkg::FREE_W-1:0]  free_bytes;

    modport source (output valid, output status, output data_offset,
                    output free_bytes, input ready);
    modport sink   (input valid, input status, input data_offset,
                    input free_bytes, output ready);
endinterface

// ===== design/ffha_ram.sv =====
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/first_fit_heap_allocator.sv =====
// First-fit heap allocator over a fixed byte pool. Each request transaction either allocates
// (action 0, request_bytes) or frees (action 1, release_offset) and returns exactly one
// response transaction with a status, the data offset of an allocated block and the free
// byte total after the request. All block bookkeeping is done in units of ALIGN_BYTES
// slots: one header per slot lives in a single-port-write, single-port-read RAM with a
// registered read. After reset the block writes the header of the initial free block
// and then accepts requests. A request first has its byte count or offset divided by
// ALIGN_BYTES with a reciprocal multiplication, then walks the header chain one RAM read
// per block. An allocate merges the free neighbors of a free block on the way and splits
// the chosen block when enough is left over for a new free block. Rejected requests skip
// the header walk. A response waits for the sink in an output register, and the next
// request is taken while the previous response is still waiting.
module first_fit_heap_allocator #(
    parameter int POOL_BYTES         = 4096,
    parameter int ALIGN_BYTES        = 8,
    parameter int POOL_HEADER_BYTES  = 32,
    parameter int BLOCK_HEADER_BYTES = 8
) (
    input logic        clk,
    input logic        rst_n,
    ffha_req_if.sink   request,
    ffha_rsp_if.source response
);

    import ffha_pkg::*;

    // Pool geometry in slots.
    localparam int END_SLOT = POOL_BYTES / ALIGN_BYTES;
    localparam int PH_SLOT  = (POOL_HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int BH_SLOT  = (BLOCK_HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int SW       = $clog2(END_SLOT + 1);
    localparam int AW       = $clog2(END_SLOT);
    localparam int HW       = SW + 1;
    localparam int RMW      = $clog2(ALIGN_BYTES);
    localparam int CW       = ((SW > DIV_W + 1) ? SW : DIV_W + 1) + 1;

    // Reciprocal of ALIGN_BYTES; exact for every DIV_W-bit dividend.
    localparam int RCP_SHIFT = DIV_W + RMW;
    localparam int RCP_MUL   = ((1 << RCP_SHIFT) + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int RCP_W     = DIV_W + 1;
    localparam int PW        = DIV_W + RCP_W;

    state_t state_reg, state_next;

    logic                 act_reg, act_next;
    logic [DIV_W-1:0]     div_reg, div_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [RMW-1:0]       rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SW-1:0]        wanted_reg, wanted_next;
    logic [SW-1:0]        target_reg, target_next;
    logic [SW-1:0]        blk_reg, blk_next;
    logic [SW-1:0]        nxt_reg, nxt_next;
    logic [SW-1:0]        free_reg, free_next;
    status_t              res_status_reg, res_status_next;
    logic [SW-1:0]        res_data_reg, res_data_next;

    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [OFF_W-1:0]     out_data_reg, out_data_next;
    logic [FREE_W-1:0]    out_free_reg, out_free_next;

    logic                 ram_wr_en;
    logic [AW-1:0]        ram_wr_addr;
    logic [HW-1:0]        ram_wr_data;
    logic                 ram_rd_en;
    logic [AW-1:0]        ram_rd_addr;
    logic [HW-1:0]        ram_rd_data;

    ffha_ram #(
        .WIDTH (HW),
        .DEPTH (END_SLOT)
    ) u_hdr_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Division by ALIGN_BYTES: the quotient comes from a multiply by the reciprocal and is
    // registered, then the remainder comes from the registered quotient.
    logic [PW-1:0]    rcp_prod;
    logic [DIV_W-1:0] rcp_quo;
    logic [DIV_W-1:0] quo_scaled;
    logic [RMW-1:0]   rcp_rem;

    assign rcp_prod   = PW'(div_reg) * PW'(RCP_MUL);
    assign rcp_quo    = DIV_W'(rcp_prod >> RCP_SHIFT);
    assign quo_scaled = DIV_W'(32'(quo_reg) * 32'(ALIGN_BYTES));
    assign rcp_rem    = RMW'(div_reg - quo_scaled);

    // Request checks once the quotient and remainder are known.
    logic          rem_nz;
    logic [CW-1:0] wanted_c;
    logic          size_reject;
    logic          off_outside;

    assign rem_nz      = rem_reg != '0;
    assign wanted_c    = CW'(div_reg) + CW'(rem_nz);
    assign size_reject = (wanted_c == '0) || (wanted_c > CW'(free_reg));
    assign off_outside = ((div_reg == '0) && !rem_nz) || (CW'(div_reg) >= CW'(END_SLOT));

    // Header just read from the RAM.
    logic [SW-1:0] rd_nxt;
    logic          rd_free;
    logic          rd_fwd;
    logic          rd_in_pool;
    logic          free_hit;
    logic          merge_go;

    assign rd_nxt     = ram_rd_data[SW-1:0];
    assign rd_free    = ram_rd_data[SW];
    assign rd_fwd     = rd_nxt > blk_reg;
    assign rd_in_pool = CW'(rd_nxt) < CW'(END_SLOT);
    assign free_hit   = (CW'(blk_reg) + CW'(BH_SLOT)) == CW'(target_reg);
    assign merge_go   = rd_free && (rd_nxt > nxt_reg);

    // Fit decision on a free block whose merged end is in nxt_reg.
    logic [CW-1:0] span;
    logic [CW-1:0] need_take;
    logic          fit_ok;
    logic          fit_split;
    logic [CW-1:0] split_blk;
    logic          nxt_at_end;
    logic [CW-1:0] take_amt;
    logic [SW-1:0] free_after_take;
    logic [SW-1:0] free_after_release;

    assign span       = CW'(nxt_reg) - CW'(blk_reg);
    assign need_take  = CW'(BH_SLOT) + CW'(wanted_reg);
    assign fit_ok     = (nxt_reg > blk_reg) && (span >= need_take);
    assign fit_split  = span > (need_take + CW'(BH_SLOT));
    assign split_blk  = CW'(blk_reg) + need_take;
    assign nxt_at_end = CW'(nxt_reg) >= CW'(END_SLOT);
    assign take_amt   = fit_split ? need_take : span;
    assign free_after_take = (CW'(free_reg) >= take_amt) ? SW'(CW'(free_reg) - take_amt)
                                                         : '0;
    assign free_after_release = free_reg + (rd_nxt - blk_reg);

    logic load_out;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || response.ready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (request.valid)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (act_reg == ACTION_ALLOC)
                begin
                    state_next = size_reject ? S_DONE : S_READ;
                end
                else
                begin
                    state_next = (off_outside || rem_nz) ? S_DONE : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_BLOCK;
            end
            S_BLOCK:
            begin
                if (act_reg == ACTION_ALLOC)
                begin
                    if (rd_free)
                    begin
                        state_next = (rd_in_pool && rd_fwd) ? S_MERGE : S_FIT;
                    end
                    else if (!rd_in_pool || !rd_fwd)
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (!rd_fwd || free_hit || !rd_in_pool)
                begin
                    state_next = S_DONE;
                end
            end
            S_MERGE:
            begin
                if (!merge_go || !rd_in_pool)
                begin
                    state_next = S_FIT;
                end
            end
            S_FIT:
            begin
                if (fit_ok)
                begin
                    state_next = fit_split ? S_SPLIT : S_DONE;
                end
                else if (!(nxt_reg > blk_reg) || nxt_at_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_BLOCK;
                end
            end
            S_SPLIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // Datapath, RAM control and handshake outputs.
    always_comb
    begin
        act_next        = act_reg;
        div_next        = div_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        wanted_next     = wanted_reg;
        target_next     = target_reg;
        blk_next        = blk_reg;
        nxt_next        = nxt_reg;
        free_next       = free_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = blk_reg[AW-1:0];
        ram_wr_data     = {1'b1, nxt_reg};
        ram_rd_en       = 1'b0;
        ram_rd_addr     = blk_reg[AW-1:0];
        request.ready   = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                // The initial block covers the whole pool behind the pool header.
                ram_wr_en   = 1'b1;
                ram_wr_addr = AW'(PH_SLOT);
                ram_wr_data = {1'b1, SW'(END_SLOT)};
                free_next   = SW'(END_SLOT - PH_SLOT);
            end
            S_IDLE:
            begin
                request.ready = 1'b1;
                act_next      = request.action;
                div_next      = (request.action == ACTION_FREE) ? DIV_W'(request.release_offset)
                                                                : DIV_W'(request.request_bytes);
                rem_next      = '0;
                cnt_next      = '0;
                res_data_next = '0;
                blk_next      = SW'(PH_SLOT);
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    quo_next = rcp_quo;
                end
                else
                begin
                    rem_next = rcp_rem;
                    div_next = quo_reg;
                end
            end
            S_CHECK:
            begin
                wanted_next = SW'(wanted_c);
                target_next = SW'(div_reg);
                if (act_reg == ACTION_ALLOC)
                begin
                    res_status_next = STATUS_SIZE;
                end
                else
                begin
                    res_status_next = off_outside ? STATUS_OUTSIDE : STATUS_NOTFOUND;
                end
            end
            S_READ:
            begin
                ram_rd_en = 1'b1;
            end
            S_BLOCK:
            begin
                nxt_next = rd_nxt;
                if (act_reg == ACTION_ALLOC)
                begin
                    res_status_next = STATUS_OOM;
                    if (rd_free)
                    begin
                        if (rd_in_pool && rd_fwd)
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = rd_nxt[AW-1:0];
                        end
                    end
                    else if (rd_in_pool && rd_fwd)
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = rd_nxt[AW-1:0];
                        blk_next    = rd_nxt;
                    end
                end
                else
                begin
                    res_status_next = STATUS_NOTFOUND;
                    if (rd_fwd && free_hit)
                    begin
                        if (!rd_free)
                        begin
                            // Release: mark free and give the whole block back.
                            ram_wr_en       = 1'b1;
                            ram_wr_data     = {1'b1, rd_nxt};
                            free_next       = free_after_release;
                            res_status_next = STATUS_OK;
                        end
                    end
                    else if (rd_fwd && rd_in_pool)
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = rd_nxt[AW-1:0];
                        blk_next    = rd_nxt;
                    end
                end
            end
            S_MERGE:
            begin
                // Absorb the free neighbor and look at the one behind it.
                if (merge_go)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = {1'b1, rd_nxt};
                    nxt_next    = rd_nxt;
                    if (rd_in_pool)
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = rd_nxt[AW-1:0];
                    end
                end
            end
            S_FIT:
            begin
                if (fit_ok)
                begin
                    free_next       = free_after_take;
                    res_status_next = STATUS_OK;
                    res_data_next   = SW'(CW'(blk_reg) + CW'(BH_SLOT));
                    ram_wr_en       = 1'b1;
                    if (fit_split)
                    begin
                        // Remainder becomes a new free block; the taken one is written next.
                        ram_wr_addr = split_blk[AW-1:0];
                        ram_wr_data = {1'b1, nxt_reg};
                    end
                    else
                    begin
                        ram_wr_data = {1'b0, nxt_reg};
                    end
                end
                else if ((nxt_reg > blk_reg) && !nxt_at_end)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = nxt_reg[AW-1:0];
                    blk_next    = nxt_reg;
                end
            end
            S_SPLIT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_data = {1'b0, SW'(split_blk)};
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Output register: holds a finished response until the sink takes it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_free_next   = out_free_reg;
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_data_next   = OFF_W'(32'(res_data_reg) * 32'(ALIGN_BYTES));
            out_free_next   = FREE_W'(32'(free_reg) * 32'(ALIGN_BYTES));
        end
        else if (response.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        div_reg        <= div_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        cnt_reg        <= cnt_next;
        wanted_reg     <= wanted_next;
        target_reg     <= target_next;
        blk_reg        <= blk_next;
        nxt_reg        <= nxt_next;
        free_reg       <= free_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_free_reg   <= out_free_next;
    end

    assign response.valid       = out_valid_reg;
    assign response.status      = out_status_reg;
    assign response.data_offset = out_data_reg;
    assign response.free_bytes  = out_free_reg;

    // A header write and a header read never touch the same slot in one cycle.
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
        else $error("header RAM read and write hit the same slot");

    // A failed response never carries a data offset.
    a_fail_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && (response.status != STATUS_OK)) |-> (response.data_offset == '0))
        else $error("failed response carries a data offset");

    // Taking a block never raises the free total.
    a_fit_no_gain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIT) |=> (free_reg <= $past(free_reg)))
        else $error("allocation increased the free total");

endmodule
